@@ src/mandel_pkg.sv @@
// Shared types and constants for the escape-time point tester.
// Used by mandel_cfg, mandel_cell and mandelbrot_escape_time; no dependencies.
package mandel_pkg;

    localparam int ITER_BITS     = 12;
    localparam int C_BITS        = 32;
    localparam int Z_BITS        = 34;
    localparam int FRAC_BITS     = 26;
    localparam int LIMIT_BITS    = 31;
    localparam int PROD_BITS     = 64;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int NUM_CELLS_DEF = 4;

    localparam logic [ITER_BITS-1:0]  MAX_ITER_RESET = ITER_BITS'(20);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = LIMIT_BITS'(536870912);

    localparam logic signed [Z_BITS-1:0] Z_BIG_POS = Z_BITS'(64'sd2147483647);
    localparam logic signed [Z_BITS-1:0] Z_BIG_NEG = Z_BITS'(-64'sd2147483647);

    localparam logic REG_MAX_ITER = 1'b0;
    localparam logic REG_LIMIT    = 1'b1;

    typedef struct packed {
        logic signed [C_BITS-1:0] c_real;
        logic signed [C_BITS-1:0] c_imag;
    } t_in;

    typedef struct packed {
        logic [ITER_BITS-1:0] iter_count;
        logic                 escaped;
    } t_out;

    typedef struct packed {
        logic [ITER_BITS-1:0]  max_iter;
        logic [LIMIT_BITS-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic                     valid;
        logic                     done;
        logic                     escaped;
        logic [ITER_BITS-1:0]     k;
        logic signed [Z_BITS-1:0] zr;
        logic signed [Z_BITS-1:0] zi;
        logic signed [C_BITS-1:0] cr;
        logic signed [C_BITS-1:0] ci;
    } t_slot;

    typedef struct packed {
        logic                        valid;
        logic                        done;
        logic                        escaped;
        logic                        big;
        logic [ITER_BITS-1:0]        k;
        logic signed [C_BITS-1:0]    cr;
        logic signed [C_BITS-1:0]    ci;
        logic signed [PROD_BITS-1:0] rr;
        logic signed [PROD_BITS-1:0] ii;
        logic signed [PROD_BITS-1:0] ri;
    } t_prod;

endpackage

@@ src/mandel_cfg.sv @@
// Configuration registers behind an APB-style port: iteration limit and
// squared escape radius. Depends on mandel_pkg.
module mandel_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mandel_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [mandel_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mandel_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                  pready,
    output mandel_pkg::t_cfg                      o_cfg
);
    import mandel_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;
    logic w_sel;

    assign w_wr   = psel & penable & pwrite;
    assign w_sel  = paddr[2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_sel)
                REG_MAX_ITER: n_cfg.max_iter = pwdata[ITER_BITS-1:0];
                REG_LIMIT:    n_cfg.limit    = pwdata[LIMIT_BITS-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_MAX_ITER: prdata = APB_DATA_BITS'(r_cfg.max_iter);
            REG_LIMIT:    prdata = APB_DATA_BITS'(r_cfg.limit);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iter <= MAX_ITER_RESET;
            r_cfg.limit    <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ src/mandel_cell.sv @@
// One iteration cell: squares z, tests the escape bound and forms the next z.
// Two register stages. Depends on mandel_pkg.
module mandel_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mandel_pkg::t_cfg  i_cfg,
    input  mandel_pkg::t_slot i_slot,
    output mandel_pkg::t_slot o_slot
);
    import mandel_pkg::*;

    t_prod r_s1;
    t_prod n_s1;
    t_slot r_s2;
    t_slot n_s2;

    logic signed [C_BITS-1:0]    w_zr;
    logic signed [C_BITS-1:0]    w_zi;
    logic [PROD_BITS-1:0]        w_sum;
    logic [PROD_BITS-1:0]        w_lim;
    logic                        w_esc;
    logic signed [PROD_BITS-1:0] w_dr;
    logic signed [Z_BITS-1:0]    w_shr;
    logic signed [Z_BITS-1:0]    w_shi;

    assign w_zr = i_slot.zr[C_BITS-1:0];
    assign w_zi = i_slot.zi[C_BITS-1:0];

    always_comb begin
        n_s1.valid   = i_slot.valid;
        n_s1.done    = i_slot.done;
        n_s1.escaped = i_slot.escaped;
        n_s1.k       = i_slot.k;
        n_s1.cr      = i_slot.cr;
        n_s1.ci      = i_slot.ci;
        n_s1.big     = (i_slot.zr > Z_BIG_POS) || (i_slot.zr < Z_BIG_NEG) ||
                       (i_slot.zi > Z_BIG_POS) || (i_slot.zi < Z_BIG_NEG);
        n_s1.rr      = w_zr * w_zr;
        n_s1.ii      = w_zi * w_zi;
        n_s1.ri      = w_zr * w_zi;
    end

    assign w_sum = $unsigned(r_s1.rr) + $unsigned(r_s1.ii);
    assign w_lim = {{(PROD_BITS-LIMIT_BITS-FRAC_BITS){1'b0}}, i_cfg.limit,
                    {FRAC_BITS{1'b0}}};
    assign w_esc = r_s1.big || (w_sum > w_lim);
    assign w_dr  = r_s1.rr - r_s1.ii;
    assign w_shr = w_dr[FRAC_BITS+Z_BITS-1:FRAC_BITS];
    assign w_shi = r_s1.ri[FRAC_BITS+Z_BITS-2:FRAC_BITS-1];

    always_comb begin
        n_s2.valid   = r_s1.valid;
        n_s2.done    = r_s1.done;
        n_s2.escaped = r_s1.escaped;
        n_s2.k       = r_s1.k;
        n_s2.cr      = r_s1.cr;
        n_s2.ci      = r_s1.ci;
        n_s2.zr      = w_shr + Z_BITS'(r_s1.cr);
        n_s2.zi      = w_shi + Z_BITS'(r_s1.ci);
        if (r_s1.valid && !r_s1.done) begin
            if (w_esc) begin
                n_s2.done    = 1'b1;
                n_s2.escaped = 1'b1;
            end else if (r_s1.k == i_cfg.max_iter) begin
                n_s2.done    = 1'b1;
                n_s2.escaped = 1'b0;
            end else begin
                n_s2.k = r_s1.k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_slot = r_s2;

endmodule

@@ src/mandelbrot_escape_time.sv @@
// Escape-time point tester: a ring of NUM_CELLS iteration cells.
// One point is in the ring at a time; a new request is taken the cycle after
// the result leaves the ring.
// Reset (synchronous, active low): ring and output empty, registers at defaults.
// Depends on mandel_pkg, mandel_cfg and mandel_cell.
module mandelbrot_escape_time #(
    parameter int NUM_CELLS = mandel_pkg::NUM_CELLS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mandel_pkg::t_in                       i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mandel_pkg::t_out                      o_out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mandel_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [mandel_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mandel_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                  pready
);
    import mandel_pkg::*;

    t_cfg  w_cfg;
    t_slot w_head;
    t_slot w_last;
    t_slot w_slot [NUM_CELLS];
    logic  w_accept;
    logic  w_leave;
    logic  r_busy;
    logic  n_busy;
    logic  r_out_valid;
    logic  n_out_valid;
    t_out  r_out;

    mandel_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_first
            mandel_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (w_cfg),
                .i_slot  (w_head),
                .o_slot  (w_slot[g])
            );
        end else begin : g_next
            mandel_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (w_cfg),
                .i_slot  (w_slot[g-1]),
                .o_slot  (w_slot[g])
            );
        end
    end

    assign w_last     = w_slot[NUM_CELLS-1];
    assign o_in_stall = r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    assign w_leave    = w_last.valid && w_last.done && (!r_out_valid || !i_out_stall);

    // insert a new request, drop a finished point as it leaves, or else recirculate the last cell's slot
    always_comb begin
        w_head = w_last;
        if (w_accept) begin
            w_head.valid   = 1'b1;
            w_head.done    = 1'b0;
            w_head.escaped = 1'b0;
            w_head.k       = '0;
            w_head.zr      = '0;
            w_head.zi      = '0;
            w_head.cr      = i_in_data.c_real;
            w_head.ci      = i_in_data.c_imag;
        end else if (w_leave) begin
            w_head.valid = 1'b0;
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_leave) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid && i_out_stall;
        if (w_leave) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_leave) begin
            r_out.iter_count <= w_last.k;
            r_out.escaped    <= w_last.escaped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
